FILE: hw/rtl/pgs_pkg.sv
// Shared types and constants of the path gradient smoother.
`timescale 1ns / 1ps
`default_nettype none
package pgs_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned TOL_W    = 32;
  localparam int unsigned CHANGE_W = 40;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CIDX_W   = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_DATA_RST   = 16'd32768;
  localparam logic [WEIGHT_W-1:0] WEIGHT_SMOOTH_RST = 16'd6554;
  localparam logic [TOL_W-1:0]    TOLERANCE_RST     = 32'd1;

  typedef enum logic [CIDX_W-1:0] {
    REG_WEIGHT_DATA   = 2'd0,
    REG_WEIGHT_SMOOTH = 2'd1,
    REG_TOLERANCE     = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD_L,
    S_RD_C,
    S_RD_R,
    S_LATCH,
    S_ISSUE,
    S_WAIT,
    S_ABS,
    S_WR,
    S_CHK,
    S_OUT_RD,
    S_OUT
  } state_e;

  // One weighted step: result = sat(base + round((a + b - 2c) * w / 2^16))
  typedef struct packed {
    logic [COORD_W-1:0]  a;
    logic [COORD_W-1:0]  b;
    logic [COORD_W-1:0]  c;
    logic [COORD_W-1:0]  base;
    logic [WEIGHT_W-1:0] w;
  } alu_op_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pgs_ram.sv
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pgs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data when no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/pgs_alu.sv
// Shared three-stage weighted-step unit: difference, multiply, round and saturate.
`timescale 1ns / 1ps
`default_nettype none
module pgs_alu (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             issue_i,
  input  wire pgs_pkg::alu_op_t                 op_i,
  output logic                                  done_o,
  output logic      [pgs_pkg::COORD_W-1:0]      res_o
);
  import pgs_pkg::*;

  localparam int unsigned DIFF_W = COORD_W + 2;
  localparam int unsigned PROD_W = DIFF_W + WEIGHT_W + 1;
  localparam int unsigned STEP_W = PROD_W - WEIGHT_W;
  localparam int unsigned SUM_W  = STEP_W + 1;

  logic v1_q, v2_q, v3_q;
  logic signed [DIFF_W-1:0] diff_d, diff_q;
  logic [WEIGHT_W-1:0]      w_q;
  logic [COORD_W-1:0]       base1_q, base2_q;
  logic signed [PROD_W-1:0] prod_q, rnd;
  logic signed [STEP_W-1:0] step;
  logic signed [SUM_W-1:0]  sum;
  logic [COORD_W-1:0]       res_q;

  assign diff_d = $signed({{2{op_i.a[COORD_W-1]}}, op_i.a})
                + $signed({{2{op_i.b[COORD_W-1]}}, op_i.b})
                - $signed({op_i.c[COORD_W-1], op_i.c, 1'b0});

  // Round half up, then floor shift.
  assign rnd  = prod_q + $signed(PROD_W'(32768));
  assign step = rnd[PROD_W-1:WEIGHT_W];
  assign sum  = $signed({{(SUM_W-COORD_W){base2_q[COORD_W-1]}}, base2_q})
              + $signed({step[STEP_W-1], step});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      diff_q  <= diff_d;
      w_q     <= op_i.w;
      base1_q <= op_i.base;
    end
    if (v1_q) begin
      prod_q  <= diff_q * $signed({1'b0, w_q});
      base2_q <= base1_q;
    end
    if (v2_q) begin
      if (sum > $signed(SUM_W'(32'h7FFF_FFFF))) begin
        res_q <= 32'h7FFF_FFFF;
      end else if (sum < -$signed(SUM_W'(33'h0_8000_0000))) begin
        res_q <= 32'h8000_0000;
      end else begin
        res_q <= sum[COORD_W-1:0];
      end
    end
  end

  assign done_o = v3_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

FILE: hw/rtl/path_gradient_smoother_top.sv
// Top level of the path gradient smoother: loader, sweep sequencer and output streamer.
`timescale 1ns / 1ps
`default_nettype none
// Points stream in one beat per cycle until the beat flagged last_point; the
// path (up to MAX_POINTS points, extras dropped) is kept twice, as working copy
// and as originals. Interior path points in the final WINDOW are then relaxed in
// place, sweep after sweep, until the summed movement of a sweep falls below
// tolerance or UPDATE_CAP+1 sweeps have run; paths of up to two points are not
// touched. Every update runs through one shared multiply unit, four weighted
// steps per point, each issued once the one before it is done. The path is then
// sent out one beat per cycle while out_ready_i is high, after a first read of
// the working copy, and the block takes no new point until the final beat has
// gone. Configuration takes effect on the next path only if the user writes it
// between paths; the block itself does not enforce it.
module path_gradient_smoother_top #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned WINDOW     = 50,
  parameter int unsigned UPDATE_CAP = 20
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pgs_pkg::CIDX_W-1:0]     cfg_idx_i,
  input  wire logic [pgs_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [pgs_pkg::COORD_W-1:0]    pos_x_i,
  input  wire logic [pgs_pkg::COORD_W-1:0]    pos_y_i,
  input  wire logic                           last_point_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [pgs_pkg::COORD_W-1:0]    smooth_x_o,
  output logic      [pgs_pkg::COORD_W-1:0]    smooth_y_o,
  output logic                                last_out_o
);
  import pgs_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_POINTS);
  localparam int unsigned CW     = $clog2(MAX_POINTS + 1);
  localparam int unsigned SWW    = $clog2(UPDATE_CAP + 1);
  localparam int unsigned WORD_W = 2 * COORD_W;
  localparam int unsigned ABS_W  = COORD_W + 1;
  localparam int unsigned ACC_W  = CHANGE_W + 2;

  // Configuration registers
  logic [WEIGHT_W-1:0] wd_q, ws_q;
  logic [TOL_W-1:0]    tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_q  <= WEIGHT_DATA_RST;
      ws_q  <= WEIGHT_SMOOTH_RST;
      tol_q <= TOLERANCE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WEIGHT_DATA:   wd_q  <= cfg_data_i[WEIGHT_W-1:0];
        REG_WEIGHT_SMOOTH: ws_q  <= cfg_data_i[WEIGHT_W-1:0];
        REG_TOLERANCE:     tol_q <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;

  logic [CW-1:0]       cnt_q;
  logic [AW-1:0]       first_q, idx_q, out_k_q;
  logic [SWW-1:0]      sw_q;
  logic [CHANGE_W-1:0] change_q;
  logic [1:0]          op_q;

  logic [COORD_W-1:0] left_x_q, left_y_q, cur_x_q, cur_y_q, right_x_q, right_y_q;
  logic [COORD_W-1:0] orig_x_q, orig_y_q, v_q, new_x_q, new_y_q;
  logic [ABS_W-1:0]   dx_q, dy_q;

  // Memory ports
  logic              wk_we, wk_re, og_we, og_re;
  logic [AW-1:0]     wk_waddr, wk_raddr, og_raddr;
  logic [WORD_W-1:0] wk_wdata, wk_rdata, og_rdata;

  // Shared unit
  logic               alu_issue, alu_done;
  alu_op_t            alu_op;
  logic [COORD_W-1:0] alu_res;

  logic               in_beat, out_beat, short_path, more_points, out_last;
  logic               repeat_sweep;
  logic [CW-1:0]      n_next;
  logic [AW-1:0]      first_next;
  logic [TOL_W-1:0]   tol_eff;
  logic [ACC_W-1:0]   acc_sum;
  logic [CHANGE_W-1:0] change_next;

  function automatic logic [ABS_W-1:0] abs_diff(input logic [COORD_W-1:0] p,
                                                input logic [COORD_W-1:0] q);
    logic signed [ABS_W-1:0] d;
    d = $signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q});
    return d[ABS_W-1] ? ABS_W'(-d) : ABS_W'(d);
  endfunction

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  assign n_next = (cnt_q < CW'(MAX_POINTS)) ? cnt_q + CW'(1) : cnt_q;
  assign short_path = (n_next <= CW'(2));
  assign first_next = (32'(n_next) > 32'(WINDOW)) ? AW'(32'(n_next) - 32'(WINDOW))
                                                  : AW'(1);
  assign more_points = (CW'(idx_q) + CW'(2)) < cnt_q;
  assign out_last    = (CW'(out_k_q) == cnt_q - CW'(1));

  assign tol_eff = (tol_q == '0) ? TOL_W'(1) : tol_q;
  assign repeat_sweep = (change_q >= CHANGE_W'(tol_eff)) && (sw_q < SWW'(UPDATE_CAP));

  // Saturating movement sum
  assign acc_sum = ACC_W'(change_q) + ACC_W'(dx_q) + ACC_W'(dy_q);
  assign change_next = (acc_sum[ACC_W-1:CHANGE_W] != '0) ? {CHANGE_W{1'b1}}
                                                         : acc_sum[CHANGE_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_beat && last_point_i) begin
          state_d = short_path ? S_OUT_RD : S_RD_L;
        end
      end
      S_RD_L:  state_d = S_RD_C;
      S_RD_C:  state_d = S_RD_R;
      S_RD_R:  state_d = S_LATCH;
      S_LATCH: state_d = S_ISSUE;
      S_ISSUE: state_d = S_WAIT;
      S_WAIT: begin
        if (alu_done) begin
          state_d = (op_q == 2'd3) ? S_ABS : S_ISSUE;
        end
      end
      S_ABS:   state_d = S_WR;
      S_WR:    state_d = more_points ? S_LATCH : S_CHK;
      S_CHK:   state_d = repeat_sweep ? S_RD_L : S_OUT_RD;
      S_OUT_RD: state_d = S_OUT;
      S_OUT: begin
        if (out_beat && out_last) begin
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Outputs and memory / unit controls
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    wk_we       = 1'b0;
    wk_waddr    = cnt_q[AW-1:0];
    wk_wdata    = {pos_x_i, pos_y_i};
    og_we       = 1'b0;
    wk_re       = 1'b0;
    wk_raddr    = idx_q + AW'(1);
    og_re       = 1'b0;
    og_raddr    = idx_q;
    alu_issue   = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        wk_we      = in_beat && (cnt_q < CW'(MAX_POINTS));
        og_we      = wk_we;
      end
      S_RD_L: begin
        wk_re    = 1'b1;
        wk_raddr = first_q - AW'(1);
      end
      S_RD_C: begin
        wk_re    = 1'b1;
        wk_raddr = first_q;
      end
      S_RD_R: begin
        wk_re = 1'b1;
        og_re = 1'b1;
      end
      S_ISSUE: alu_issue = 1'b1;
      S_WR: begin
        wk_we    = 1'b1;
        wk_waddr = idx_q;
        wk_wdata = {new_x_q, new_y_q};
        wk_re    = more_points;
        wk_raddr = idx_q + AW'(2);
        og_re    = more_points;
        og_raddr = idx_q + AW'(1);
      end
      S_OUT_RD: begin
        wk_re    = 1'b1;
        wk_raddr = out_k_q;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        wk_re       = out_beat && !out_last;
        wk_raddr    = out_k_q + AW'(1);
      end
      default: ;
    endcase
  end

  // Operand selection: op bit 0 picks the smoothing step, bit 1 the y axis
  always_comb begin
    if (!op_q[0]) begin
      alu_op.a    = op_q[1] ? orig_y_q : orig_x_q;
      alu_op.b    = op_q[1] ? cur_y_q : cur_x_q;
      alu_op.c    = op_q[1] ? cur_y_q : cur_x_q;
      alu_op.base = op_q[1] ? cur_y_q : cur_x_q;
      alu_op.w    = wd_q;
    end else begin
      alu_op.a    = op_q[1] ? left_y_q : left_x_q;
      alu_op.b    = op_q[1] ? right_y_q : right_x_q;
      alu_op.c    = v_q;
      alu_op.base = v_q;
      alu_op.w    = ws_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_q    <= '0;
      first_q  <= '0;
      idx_q    <= '0;
      out_k_q  <= '0;
      sw_q     <= '0;
      change_q <= '0;
      op_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_LOAD: begin
          if (in_beat) begin
            cnt_q <= n_next;
            if (last_point_i) begin
              first_q  <= first_next;
              idx_q    <= first_next;
              sw_q     <= '0;
              change_q <= '0;
              out_k_q  <= '0;
            end
          end
        end
        S_LATCH: op_q <= '0;
        S_WAIT: begin
          if (alu_done) begin
            op_q <= op_q + 2'd1;
          end
        end
        S_WR: begin
          change_q <= change_next;
          if (more_points) begin
            idx_q <= idx_q + AW'(1);
          end
        end
        S_CHK: begin
          if (repeat_sweep) begin
            sw_q     <= sw_q + SWW'(1);
            change_q <= '0;
            idx_q    <= first_q;
          end
          out_k_q <= '0;
        end
        S_OUT: begin
          if (out_beat) begin
            if (out_last) begin
              cnt_q   <= '0;
              out_k_q <= '0;
            end else begin
              out_k_q <= out_k_q + AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Point window and step results
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_RD_C: begin
        left_x_q <= wk_rdata[WORD_W-1:COORD_W];
        left_y_q <= wk_rdata[COORD_W-1:0];
      end
      S_RD_R: begin
        cur_x_q <= wk_rdata[WORD_W-1:COORD_W];
        cur_y_q <= wk_rdata[COORD_W-1:0];
      end
      S_LATCH: begin
        right_x_q <= wk_rdata[WORD_W-1:COORD_W];
        right_y_q <= wk_rdata[COORD_W-1:0];
        orig_x_q  <= og_rdata[WORD_W-1:COORD_W];
        orig_y_q  <= og_rdata[COORD_W-1:0];
      end
      S_ISSUE: begin
        if (op_q == 2'd2) begin
          dx_q <= abs_diff(cur_x_q, new_x_q);
        end
      end
      S_WAIT: begin
        if (alu_done) begin
          if (!op_q[0]) begin
            v_q <= alu_res;
          end else if (op_q[1]) begin
            new_y_q <= alu_res;
          end else begin
            new_x_q <= alu_res;
          end
        end
      end
      S_ABS: dy_q <= abs_diff(cur_y_q, new_y_q);
      S_WR: begin
        // Slide the window: updated point becomes the left neighbor
        left_x_q <= new_x_q;
        left_y_q <= new_y_q;
        cur_x_q  <= right_x_q;
        cur_y_q  <= right_y_q;
      end
      default: ;
    endcase
  end

  pgs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_POINTS)
  ) u_work_ram (
    .clk_i  (clk_i),
    .we_i   (wk_we),
    .waddr_i(wk_waddr),
    .wdata_i(wk_wdata),
    .re_i   (wk_re),
    .raddr_i(wk_raddr),
    .rdata_o(wk_rdata)
  );

  pgs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_POINTS)
  ) u_orig_ram (
    .clk_i  (clk_i),
    .we_i   (og_we),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i({pos_x_i, pos_y_i}),
    .re_i   (og_re),
    .raddr_i(og_raddr),
    .rdata_o(og_rdata)
  );

  pgs_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .issue_i(alu_issue),
    .op_i   (alu_op),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  assign smooth_x_o = wk_rdata[WORD_W-1:COORD_W];
  assign smooth_y_o = wk_rdata[COORD_W-1:0];
  assign last_out_o = out_last;

endmodule
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for path_gradient_smoother_top: streams paths, predicts and compares.
module tb;
  import pgs_pkg::*;

  localparam int MAX_POINTS = 64;
  localparam int WINDOW = 50;
  localparam int UPDATE_CAP = 20;
  localparam longint MOVE_SUM_MAX = (longint'(1) << 40) - 1;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  // quiet limit: spans one full path of up to 21 sweeps over 49 points, with room to spare
  localparam int QUIET_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 32;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } path_pt_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CIDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [COORD_W-1:0]  pos_x_i;
  logic [COORD_W-1:0]  pos_y_i;
  logic                last_point_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [COORD_W-1:0]  smooth_x_o;
  logic [COORD_W-1:0]  smooth_y_o;
  logic                last_out_o;

  // predictor state
  int                  work_pt [2][MAX_POINTS];
  int                  orig_pt [2][MAX_POINTS];
  int                  point_updates [MAX_POINTS];
  int                  loaded = 0;
  logic [WEIGHT_W-1:0] wt_data = WEIGHT_DATA_RST;
  logic [WEIGHT_W-1:0] wt_smooth = WEIGHT_SMOOTH_RST;
  logic [TOL_W-1:0]    tol_reg = TOLERANCE_RST;
  path_pt_t            smoothed_q [$];

  int                  errors = 0;
  int                  quiet_cycles = 0;
  bit                  tx_steady = 1'b0;
  bit                  rx_steady = 1'b0;

  path_gradient_smoother_top #(
    .MAX_POINTS(MAX_POINTS),
    .WINDOW    (WINDOW),
    .UPDATE_CAP(UPDATE_CAP)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .last_point_i(last_point_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .smooth_x_o  (smooth_x_o),
    .smooth_y_o  (smooth_y_o),
    .last_out_o  (last_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint clamp32(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // round(d * w / 2^16), ties up; the arithmetic shift is a floor division
  function automatic longint weigh(longint d, logic [WEIGHT_W-1:0] w);
    longint p;
    p = d * longint'({48'b0, w}) + 32768;
    return p >>> 16;
  endfunction

  // pull one coordinate toward its original, then toward the neighbour midpoint
  function automatic longint relax_axis(int a, int i);
    longint old;
    longint v;
    longint lap;
    old = work_pt[a][i];
    v = clamp32(old + weigh(longint'(orig_pt[a][i]) - old, wt_data));
    lap = longint'(work_pt[a][i-1]) + longint'(work_pt[a][i+1]) - 2 * v;
    v = clamp32(v + weigh(lap, wt_smooth));
    work_pt[a][i] = int'(v);
    return (old > v) ? old - v : v - old;
  endfunction

  function automatic void settle_path(int n);
    longint tol;
    longint moved;
    int     first;
    tol = (tol_reg == '0) ? 1 : longint'({32'b0, tol_reg});
    foreach (point_updates[k]) point_updates[k] = 0;
    if (n <= 2) return;
    first = (n > WINDOW) ? n - WINDOW : 1;
    do begin
      moved = 0;
      for (int i = first; i + 1 < n; i++) begin
        if (point_updates[i] > UPDATE_CAP) continue;
        moved += relax_axis(0, i);
        moved += relax_axis(1, i);
        if (moved > MOVE_SUM_MAX) moved = MOVE_SUM_MAX;
        point_updates[i]++;
      end
    end while (moved >= tol);
  endfunction

  function automatic void take_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                     logic last);
    path_pt_t pt;
    // drop points beyond capacity, but still honor their last flag
    if (loaded < MAX_POINTS) begin
      work_pt[0][loaded] = x;
      orig_pt[0][loaded] = x;
      work_pt[1][loaded] = y;
      orig_pt[1][loaded] = y;
      loaded++;
    end
    if (!last) return;
    settle_path(loaded);
    for (int k = 0; k < loaded; k++) begin
      pt.x    = work_pt[0][k];
      pt.y    = work_pt[1][k];
      pt.last = (k + 1 == loaded);
      smoothed_q = {smoothed_q, pt};
    end
    loaded = 0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) take_point(pos_x_i, pos_y_i, last_point_i);
  end

  always @(posedge clk_i) begin
    path_pt_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (smoothed_q.size() == 0) begin
        $error("unexpected beat: smooth_x=%h smooth_y=%h last_out=%b",
               smooth_x_o, smooth_y_o, last_out_o);
        errors++;
      end else begin
        want = smoothed_q.pop_front();
        if (smooth_x_o !== want.x) begin
          $error("smooth_x: expected %h, got %h", want.x, smooth_x_o);
          errors++;
        end
        if (smooth_y_o !== want.y) begin
          $error("smooth_y: expected %h, got %h", want.y, smooth_y_o);
          errors++;
        end
        if (last_out_o !== want.last) begin
          $error("last_out: expected %b, got %b", want.last, last_out_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL path_gradient_smoother_top");
        $finish;
      end
    end
  end

  // result sink: hold ready until a beat is taken, then draw the next stall
  initial begin
    int stall;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pos_x_i      <= x;
    pos_y_i      <= y;
    last_point_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold off until every predicted point has come back and the block is idle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [WEIGHT_W-1:0] wd, input logic [WEIGHT_W-1:0] ws,
                              input logic [TOL_W-1:0] tol);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_WEIGHT_DATA;
    cfg_data_i <= {{(CFG_W-WEIGHT_W){1'b0}}, wd};
    @(posedge clk_i);
    cfg_idx_i  <= REG_WEIGHT_SMOOTH;
    cfg_data_i <= {{(CFG_W-WEIGHT_W){1'b0}}, ws};
    @(posedge clk_i);
    cfg_idx_i  <= REG_TOLERANCE;
    cfg_data_i <= tol;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    wt_data   = wd;
    wt_smooth = ws;
    tol_reg   = tol;
  endtask

  task automatic randomize_regs();
    logic [WEIGHT_W-1:0] w [2];
    logic [TOL_W-1:0]    tol;
    foreach (w[k]) begin
      case ($urandom_range(0, 3))
        0:       w[k] = '0;
        1:       w[k] = '1;
        default: w[k] = WEIGHT_W'($urandom);
      endcase
    end
    case ($urandom_range(0, 5))
      0:       tol = '0;
      1:       tol = 32'd1;
      2:       tol = '1;
      3:       tol = $urandom;
      default: tol = $urandom_range(1, 1 << 18);
    endcase
    program_regs(w[0], w[1], tol);
  endtask

  // noise paths hit every bit; walks look like real paths, some with large steps
  task automatic send_random_path(input int n);
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    int                 shape;
    int                 step;
    shape = $urandom_range(0, 2);
    step  = (shape == 2) ? (1 << 28) : (1 << 20);
    x = $urandom_range(0, 1 << 26) - (1 << 25);
    y = $urandom_range(0, 1 << 26) - (1 << 25);
    for (int k = 0; k < n; k++) begin
      if (shape == 0) begin
        x = $urandom;
        y = $urandom;
      end else if (k > 0) begin
        x = x + $urandom_range(0, 2 * step) - step;
        y = y + $urandom_range(0, 2 * step) - step;
      end
      send_point(x, y, k == n - 1);
    end
  endtask

  task automatic test_short_paths();
    // reset settings still in force here
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    send_point(32'h0001_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0005_8000, 32'hFFFE_0000, 1'b0);
    send_point(32'h0002_0000, 32'h0001_0000, 1'b1);
    drain_results();
  endtask

  task automatic test_saturation();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    program_regs('0, '1, '1);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    drain_results();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_zero_tolerance();
    program_regs(16'd32768, 16'd32768, '0);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0000_0000, 1'b0);
    send_point(32'h4000_0000, 32'hC000_0000, 1'b0);
    send_point(32'h0002_0000, 32'h0001_0000, 1'b0);
    send_point(32'h0003_0000, 32'h0000_0000, 1'b1);
    drain_results();
  endtask

  task automatic test_update_cap();
    // near-full smoothing with no data pull converges slowly and runs into the cap
    program_regs('0, '1, 32'd1);
    send_random_path(6);
    drain_results();
    program_regs('0, '0, 32'd1);
    send_random_path(3);
    drain_results();
  endtask

  task automatic test_random_paths();
    int sent;
    int n;
    sent = 0;
    while (sent < 20) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_results();
        randomize_regs();
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      send_random_path(n);
      sent += n;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    drain_results();
  endtask

  task automatic test_window_and_overflow();
    // 66 points: only the final window of the stored 64 moves, the last two drop
    program_regs(16'd16384, 16'd40000, 32'd1);
    send_random_path(MAX_POINTS + 2);
    drain_results();
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_WEIGHT_DATA;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    pos_x_i      <= '0;
    pos_y_i      <= '0;
    last_point_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_paths();
    test_saturation();
    test_zero_tolerance();
    test_update_cap();
    test_random_paths();
    test_window_and_overflow();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS path_gradient_smoother_top");
    end else begin
      $display("FAIL path_gradient_smoother_top");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pgs_pkg.sv
hw/rtl/pgs_ram.sv
hw/rtl/pgs_alu.sv
hw/rtl/path_gradient_smoother_top.sv
bench/tb.sv
